// ----- hdl/dbtw_pkg.sv -----
`default_nettype none

package dbtw_pkg;

    // Store geometry
    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;
    localparam int DEPTH_BITS = 24;
    localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = $clog2(STORE_SIZE);
    localparam int XW         = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW         = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int EW         = $clog2(MAX_WIDTH + 1);
    localparam int EH         = $clog2(MAX_HEIGHT + 1);

    // Field widths
    localparam int CFG_W      = 10;
    localparam int COORD_W    = 16;
    localparam int CMD_W      = 2;
    localparam int IN_TDATA_W = 56;
    localparam int OUT_TDATA_W = 32;

    localparam logic [DEPTH_BITS-1:0] INFINITY = '1;

    // Register indexes
    localparam logic REG_ACTIVE_WIDTH  = 1'b0;
    localparam logic REG_ACTIVE_HEIGHT = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_TEST  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    // Coordinate check and store address for one word
    typedef struct packed {
        logic              in_range;
        logic [ADDR_W-1:0] addr;
    } addr_info_t;

endpackage

`default_nettype wire

// ----- hdl/dbtw_ram.sv -----
`default_nettype none

module dbtw_ram #(
    parameter int DATA_W = 24,
    parameter int ADDR_W = 18
) (
    input  wire logic              aclk,
    input  wire logic              en,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [DATA_W-1:0] wdata,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    // Single port, registered read; rdata holds until the next read
    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/dbtw_addr.sv -----
`default_nettype none

module dbtw_addr (
    input  wire logic        [dbtw_pkg::CFG_W-1:0]   active_width,
    input  wire logic        [dbtw_pkg::CFG_W-1:0]   active_height,
    input  wire logic signed [dbtw_pkg::COORD_W-1:0] pos_x,
    input  wire logic signed [dbtw_pkg::COORD_W-1:0] pos_y,
    output dbtw_pkg::addr_info_t                     info
);

    import dbtw_pkg::*;

    localparam int PW = EW + YW;

    logic [EW-1:0] eff_w;
    logic [EH-1:0] eff_h;
    logic          x_neg, y_neg, x_ge, y_ge;
    logic [XW-1:0] cx;
    logic [YW-1:0] cy;
    logic [PW-1:0] prod;

    // Zero acts as one, above the maximum acts as the maximum
    always_comb begin
        if (active_width == '0) begin
            eff_w = EW'(1);
        end else if (32'(active_width) > MAX_WIDTH) begin
            eff_w = EW'(MAX_WIDTH);
        end else begin
            eff_w = EW'(active_width);
        end
        if (active_height == '0) begin
            eff_h = EH'(1);
        end else if (32'(active_height) > MAX_HEIGHT) begin
            eff_h = EH'(MAX_HEIGHT);
        end else begin
            eff_h = EH'(active_height);
        end
    end

    // Range checks
    assign x_neg = pos_x[COORD_W-1];
    assign y_neg = pos_y[COORD_W-1];
    assign x_ge  = 32'(pos_x[COORD_W-2:0]) >= 32'(eff_w);
    assign y_ge  = 32'(pos_y[COORD_W-2:0]) >= 32'(eff_h);

    // Clamp to the edges; identity when in range
    always_comb begin
        if (x_neg) begin
            cx = '0;
        end else if (x_ge) begin
            cx = XW'(eff_w - 1'b1);
        end else begin
            cx = XW'(pos_x[COORD_W-2:0]);
        end
        if (y_neg) begin
            cy = '0;
        end else if (y_ge) begin
            cy = YW'(eff_h - 1'b1);
        end else begin
            cy = YW'(pos_y[COORD_W-2:0]);
        end
    end

    // Row-major address with the active width as stride
    assign prod          = PW'(eff_w) * PW'(cy);
    assign info.addr     = ADDR_W'(prod + PW'(cx));
    assign info.in_range = !x_neg && !x_ge && !y_neg && !y_ge;

endmodule

`default_nettype wire

// ----- hdl/depth_buffer_test_and_write.sv -----
`default_nettype none

// Depth buffer with a strict less-than depth test.
// Input words on s_*: s_tuser carries the command (test and write, clamped
// read, write if in range, clear); s_tdata carries the coordinates and the
// candidate depth. Each input word yields exactly one result word on m_*.
// Registers active_width and active_height are written through cfg_we /
// cfg_addr / cfg_wdata; the user must write them only while the block is
// idle; the block itself does not enforce this. Test, read and write pass
// through READ and EXEC after acceptance: acceptance registers the item
// with its address, READ reads the memory, and EXEC compares, writes back
// and loads the output register. The single memory port is used for the
// read and then the write, and no new word is taken until the result is
// loaded. Clear sweeps all 262144 entries, one per cycle, and then raises
// m_tvalid from EXEC. After aresetn the same sweep fills the store with the
// infinity code; s_tready stays low meanwhile, config writes work.
// If the receiver stalls, the result waits in the output register and the
// block holds the next item in its compare stage until the register frees.
module depth_buffer_test_and_write (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // configuration
    input  wire logic                                cfg_we,
    input  wire logic                                cfg_addr,
    input  wire logic [dbtw_pkg::CFG_W-1:0]          cfg_wdata,
    // input stream
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // pos_x[15:0], pos_y[31:16], new_depth[55:32]
    input  wire logic [dbtw_pkg::IN_TDATA_W-1:0]     s_tdata,
    // command[1:0]
    input  wire logic [dbtw_pkg::CMD_W-1:0]          s_tuser,
    // result stream
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // passed[0], read_depth[24:1], out_of_range[25], zero above
    output logic [dbtw_pkg::OUT_TDATA_W-1:0]         m_tdata
);

    import dbtw_pkg::*;

    typedef enum logic [4:0] {
        ST_INIT  = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_READ  = 5'b00100,
        ST_EXEC  = 5'b01000,
        ST_CLEAR = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;
    logic [CFG_W-1:0]       width_reg, width_next;
    logic [CFG_W-1:0]       height_reg, height_next;
    logic [ADDR_W-1:0]      sweep_reg, sweep_next;
    cmd_t                   cmd_reg, cmd_next;
    logic [DEPTH_BITS-1:0]  depth_reg, depth_next;
    addr_info_t             info_reg, info_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    addr_info_t             in_info;
    logic                   in_fire;
    logic                   exec_fire;
    logic                   sweep_last;
    logic                   res_passed, res_oor;
    logic [DEPTH_BITS-1:0]  res_depth;

    logic                   ram_en, ram_we;
    logic [ADDR_W-1:0]      ram_addr;
    logic [DEPTH_BITS-1:0]  ram_wdata, ram_rdata;

    dbtw_addr u_addr (
        .active_width  (width_reg),
        .active_height (height_reg),
        .pos_x         ($signed(s_tdata[15:0])),
        .pos_y         ($signed(s_tdata[31:16])),
        .info          (in_info)
    );

    dbtw_ram #(
        .DATA_W (DEPTH_BITS),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign s_tready   = (state_reg == ST_IDLE);
    assign in_fire    = s_tvalid && s_tready;
    assign exec_fire  = (state_reg == ST_EXEC) && (!m_tvalid_reg || m_tready);
    assign sweep_last = (sweep_reg == ADDR_W'(STORE_SIZE - 1));

    // Result of the compare stage
    always_comb begin
        res_passed = (cmd_reg == CMD_TEST) && info_reg.in_range && (ram_rdata > depth_reg);
        res_oor    = ((cmd_reg == CMD_TEST) || (cmd_reg == CMD_WRITE)) && !info_reg.in_range;
        res_depth  = (cmd_reg == CMD_READ) ? ram_rdata : '0;
    end

    // Memory port: sweep, read for a new word, or write-back
    always_comb begin
        ram_en    = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = info_reg.addr;
        ram_wdata = depth_reg;
        case (state_reg)
            ST_INIT, ST_CLEAR: begin
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                ram_addr  = sweep_reg;
                ram_wdata = INFINITY;
            end
            ST_READ: begin
                ram_en = 1'b1;
            end
            ST_EXEC: begin
                ram_en = exec_fire &&
                         (res_passed || ((cmd_reg == CMD_WRITE) && info_reg.in_range));
                ram_we = 1'b1;
            end
            default: begin
                ram_en = 1'b0;
            end
        endcase
    end

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        sweep_next    = sweep_reg;
        cmd_next      = cmd_reg;
        depth_next    = depth_reg;
        info_next     = info_reg;
        m_tvalid_next = m_tready ? 1'b0 : m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        case (state_reg)
            ST_INIT: begin
                sweep_next = sweep_reg + 1'b1;
                if (sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_fire) begin
                    cmd_next   = cmd_t'(s_tuser);
                    depth_next = s_tdata[32 +: DEPTH_BITS];
                    info_next  = in_info;
                    sweep_next = '0;
                    state_next = (cmd_t'(s_tuser) == CMD_CLEAR) ? ST_CLEAR : ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (exec_fire) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = OUT_TDATA_W'({res_oor, res_depth, res_passed});
                    state_next    = ST_IDLE;
                end
            end
            ST_CLEAR: begin
                sweep_next = sweep_reg + 1'b1;
                if (sweep_last) begin
                    state_next = ST_EXEC;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Configuration registers
    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we) begin
            case (cfg_addr)
                REG_ACTIVE_WIDTH:  width_next  = cfg_wdata;
                REG_ACTIVE_HEIGHT: height_next = cfg_wdata;
                default:           width_next  = width_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            sweep_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            width_reg    <= CFG_W'(512);
            height_reg   <= CFG_W'(512);
        end else begin
            state_reg    <= state_next;
            sweep_reg    <= sweep_next;
            m_tvalid_reg <= m_tvalid_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        depth_reg   <= depth_next;
        info_reg    <= info_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks
    a_result_from_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_EXEC))
        else $error("result appeared outside the compare stage");

    a_no_write_on_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_en && ram_we) |-> (state_reg == ST_EXEC || state_reg == ST_CLEAR ||
                                state_reg == ST_INIT))
        else $error("memory write in a read or idle state");

    a_accept_next: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> (state_reg == ST_READ || state_reg == ST_CLEAR))
        else $error("accepted word did not start a memory access");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> !(m_tdata_reg[0] && m_tdata_reg[DEPTH_BITS + 1]))
        else $error("passed and out_of_range both set");

    a_oor_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (exec_fire && !info_reg.in_range && cmd_reg != CMD_CLEAR) |-> !ram_en)
        else $error("out-of-range coordinate reached the store");

endmodule

`default_nettype wire
